### hw/rtl/mscd_pkg.sv
// ----------------------------------------------------------------------------
// mscd_pkg
// Types, opcode codes and the command size lookup for the sequence
// command decoder.
// ----------------------------------------------------------------------------
package mscd_pkg;

	// event kinds
	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_NOTE = 2'd1;
	localparam logic [1:0] KIND_REST = 2'd2;
	localparam logic [1:0] KIND_END  = 2'd3;

	// flow kinds
	localparam logic [2:0] FLOW_NONE       = 3'd0;
	localparam logic [2:0] FLOW_REPEAT     = 3'd1;
	localparam logic [2:0] FLOW_REPEAT_END = 3'd2;
	localparam logic [2:0] FLOW_BREAK      = 3'd3;
	localparam logic [2:0] FLOW_END        = 3'd4;

	// opcodes with an effect in the extended range
	localparam logic [7:0] OP_EXT_BASE   = 8'hE0;
	localparam logic [7:0] OP_TRANSPOSE  = 8'hE2;
	localparam logic [7:0] OP_OCT_UP     = 8'hE4;
	localparam logic [7:0] OP_OCT_DOWN   = 8'hE5;
	localparam logic [7:0] OP_REPEAT     = 8'hEC;
	localparam logic [7:0] OP_REPEAT_END = 8'hED;
	localparam logic [7:0] OP_BREAK      = 8'hEE;
	localparam logic [7:0] OP_END        = 8'hF5;
	localparam logic [7:0] COUNT_FOREVER = 8'hFF;

	localparam int NUM_OPERANDS = 5;
	localparam int QUEUE_DEPTH  = 2;

	// one assembled command
	typedef struct packed {
		logic [7:0]                        opcode;
		logic [2:0]                        len;
		logic [NUM_OPERANDS-1:0][7:0]      operands;
	} cmd_t;

	// one decoded event
	typedef struct packed {
		logic [1:0]                        event_kind;
		logic [7:0]                        opcode;
		logic [2:0]                        command_length;
		logic [NUM_OPERANDS-1:0][7:0]      operands;
		logic [11:0]                       pitch;
		logic [7:0]                        duration;
		logic [2:0]                        flow_kind;
		logic [7:0]                        repeat_count;
	} event_t;

	// size table for the extended opcodes E0..F6
	function automatic logic [2:0] ext_size(input logic [4:0] idx);
		logic [2:0] s;
		case (idx)
			5'd0, 5'd1, 5'd2, 5'd3: s = 3'd2;
			5'd8:                   s = 3'd6;
			5'd9:                   s = 3'd2;
			5'd12:                  s = 3'd2;
			5'd17:                  s = 3'd3;
			5'd18:                  s = 3'd2;
			5'd19:                  s = 3'd6;
			5'd20:                  s = 3'd2;
			5'd22:                  s = 3'd2;
			default:                s = 3'd1;
		endcase
		return s;
	endfunction

	// total command length from the opcode byte
	function automatic logic [2:0] cmd_len(input logic [7:0] b);
		logic [2:0] l;
		if (b inside {[8'h00:8'h3F]}) begin
			l = b[5] ? 3'd1 : 3'd2;
		end else if (b inside {[8'hE0:8'hF6]}) begin
			l = ext_size(b[4:0]);
		end else begin
			l = 3'd1;
		end
		return l;
	endfunction

endpackage

### hw/rtl/mscd_front.sv
// ----------------------------------------------------------------------------
// mscd_front
// Takes the byte stream, sizes each command from its opcode and collects
// operand bytes; hands a finished command to the queue.
// ----------------------------------------------------------------------------
module mscd_front import mscd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [2:0]                   remaining_q;
	logic [7:0]                   opcode_q;
	logic [2:0]                   len_q;
	logic [NUM_OPERANDS-1:0][7:0] operands_q;

	logic                         accept;
	logic [2:0]                   len_in;
	logic [2:0]                   idx;
	logic [NUM_OPERANDS-1:0][7:0] operands_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign len_in   = cmd_len(in_byte);
	assign idx      = len_q - 3'd1 - remaining_q;

	// operand buffer with the current byte placed
	always_comb begin
		operands_next = operands_q;
		if (remaining_q == 3'd0) begin
			operands_next = '0;
		end else begin
			for (int i = 0; i < NUM_OPERANDS; i++) begin
				if (idx == 3'(i)) operands_next[i] = in_byte;
			end
		end
	end

	// completion and record
	always_comb begin
		push_cmd.opcode   = (remaining_q == 3'd0) ? in_byte : opcode_q;
		push_cmd.len      = (remaining_q == 3'd0) ? len_in : len_q;
		push_cmd.operands = operands_next;
		if (remaining_q == 3'd0) begin
			push = accept && (len_in == 3'd1);
		end else begin
			push = accept && (remaining_q == 3'd1);
		end
	end

	// command assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= 3'd0;
			opcode_q    <= 8'd0;
			len_q       <= 3'd1;
			operands_q  <= '0;
		end else if (accept) begin
			operands_q <= operands_next;
			if (remaining_q == 3'd0) begin
				opcode_q    <= in_byte;
				len_q       <= len_in;
				remaining_q <= len_in - 3'd1;
			end else begin
				remaining_q <= remaining_q - 3'd1;
			end
		end
	end

endmodule

### hw/rtl/mscd_queue.sv
// ----------------------------------------------------------------------------
// mscd_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module mscd_queue import mscd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output cmd_t pop_cmd
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	cmd_t                        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]               wr_ptr_q;
	logic [PW-1:0]               rd_ptr_q;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;
	assign pop_cmd   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mscd_back.sv
// ----------------------------------------------------------------------------
// mscd_back
// Carries out queued commands: keeps octave, note length, transpose and
// gate, forms the decoded event and holds it in the output register.
// ----------------------------------------------------------------------------
module mscd_back import mscd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	input  cmd_t   cmd,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output event_t out_event
);

	logic [7:0] octave_q;
	logic [7:0] note_len_q;
	logic [7:0] transpose_q;
	logic [2:0] gate_q;
	logic       out_valid_q;
	event_t     out_q;

	logic [7:0]  octave_next;
	logic [7:0]  note_len_next;
	logic [7:0]  transpose_next;
	logic [2:0]  gate_next;
	logic [11:0] oct_x;
	logic [11:0] trn_x;
	logic [11:0] note_pitch;
	logic [3:0]  key;
	event_t      ev;

	assign pop       = cmd_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_event = out_q;
	assign key       = cmd.opcode[3:0];

	// pitch: octave * 12 + key - 13 + transpose, 12-bit wrap
	assign oct_x      = {{4{octave_q[7]}}, octave_q};
	assign trn_x      = {{4{transpose_q[7]}}, transpose_q};
	assign note_pitch = (oct_x << 3) + (oct_x << 2) + {8'd0, key} - 12'd13 + trn_x;

	// execute one command
	always_comb begin
		octave_next       = octave_q;
		note_len_next     = note_len_q;
		transpose_next    = transpose_q;
		gate_next         = gate_q;
		ev.event_kind     = KIND_CMD;
		ev.opcode         = cmd.opcode;
		ev.command_length = cmd.len;
		ev.operands       = cmd.operands;
		ev.pitch          = 12'hFFF;
		ev.duration       = 8'd0;
		ev.flow_kind      = FLOW_NONE;
		ev.repeat_count   = 8'd0;
		if (cmd.opcode inside {[8'h00:8'h3F]}) begin
			if (!cmd.opcode[5]) note_len_next = cmd.operands[0];
			ev.duration = note_len_next;
			if (key != 4'd0) begin
				ev.event_kind = KIND_NOTE;
				ev.pitch      = note_pitch;
			end else begin
				ev.event_kind = KIND_REST;
			end
		end else if (cmd.opcode inside {[8'h40:8'h47]}) begin
			octave_next = {5'd0, cmd.opcode[2:0]};
		end else if (cmd.opcode inside {[8'h48:8'h4F]}) begin
			gate_next = cmd.opcode[2:0];
		end else begin
			case (cmd.opcode)
				OP_TRANSPOSE: transpose_next = cmd.operands[0];
				OP_OCT_UP:    octave_next = octave_q + 8'd1;
				OP_OCT_DOWN:  octave_next = octave_q - 8'd1;
				OP_REPEAT: begin
					ev.flow_kind    = FLOW_REPEAT;
					ev.repeat_count = (cmd.operands[0] == COUNT_FOREVER) ?
						8'd0 : cmd.operands[0];
				end
				OP_REPEAT_END: ev.flow_kind = FLOW_REPEAT_END;
				OP_BREAK:      ev.flow_kind = FLOW_BREAK;
				OP_END: begin
					ev.flow_kind  = FLOW_END;
					ev.event_kind = KIND_END;
				end
				default: ;
			endcase
		end
	end

	// track state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q    <= 8'd3;
			note_len_q  <= 8'd1;
			transpose_q <= 8'd0;
			gate_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				octave_q    <= octave_next;
				note_len_q  <= note_len_next;
				transpose_q <= transpose_next;
				gate_q      <= gate_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) out_q <= ev;
	end

endmodule

### hw/rtl/music_sequence_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// music_sequence_command_decoder_unit
// Decodes a music track's bytecode stream into one event per command.
//
//   channel  dir  signals                      content
//   s_axis   in   tvalid tready tdata[7:0]     one stream byte per item
//   m_axis   out  tvalid tready tdata tuser    one decoded event per item
//
// One byte per cycle is taken while the command queue is not full; an
// event leaves through the queue entry and the output register after the
// last byte of its command.
// Reset (arst_n low) clears assembly, queue and output valid and resets track state.
// The input stalls only while the command queue is full; the back part
// stalls only on m_axis_tready.
// ----------------------------------------------------------------------------
module music_sequence_command_decoder_unit import mscd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// opcode[7:0], command_length[10:8], operand_one[18:11], operand_two[26:19],
	// operand_three[34:27], operand_four[42:35], operand_five[50:43],
	// pitch[62:51], duration[70:63], repeat_count[78:71], zero[79]
	output logic [79:0] m_axis_tdata,
	// event_kind[1:0], flow_kind[4:2]
	output logic [4:0]  m_axis_tuser
);

	logic   q_full;
	logic   push;
	cmd_t   push_cmd;
	logic   q_valid;
	logic   pop;
	cmd_t   pop_cmd;
	event_t ev;

	mscd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mscd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd)
	);

	mscd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (pop_cmd),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_event (ev)
	);

	// output packing
	assign m_axis_tdata = {1'b0, ev.repeat_count, ev.duration, ev.pitch,
		ev.operands[4], ev.operands[3], ev.operands[2], ev.operands[1],
		ev.operands[0], ev.command_length, ev.opcode};
	assign m_axis_tuser = {ev.flow_kind, ev.event_kind};

endmodule

### sim/event_ledger_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_ledger_pkg
// Tracks what the sequence command decoder should produce. Every accepted
// stream byte is folded into a copy of the track state, and each completed
// command queues the decoded event it must yield. Events leaving the block
// are matched in order against that queue, field by field.
// ----------------------------------------------------------------------------
package event_ledger_pkg;
	import mscd_pkg::*;

	// opcode class boundaries
	localparam logic [7:0] OCTAVE_BASE = 8'h40;
	localparam logic [7:0] GATE_BASE   = 8'h48;
	localparam logic [7:0] PLAIN_BASE  = 8'h50;
	localparam int         EXT_COUNT   = 23;
	localparam int         SHOW_LIMIT  = 40;

	class event_ledger;
		logic [2:0] bytes_left;
		logic [7:0] held_op;
		logic [7:0] args [NUM_OPERANDS];
		logic [7:0] octave;
		logic [7:0] note_len;
		logic [7:0] transpose;
		logic [2:0] gate;
		event_t     pending_events [$];
		int         errors;

		function new();
			bytes_left = '0;
			held_op    = '0;
			foreach (args[i]) args[i] = '0;
			octave     = 8'd3;
			note_len   = 8'd1;
			transpose  = '0;
			gate       = '0;
			errors     = 0;
		endfunction

		// command length in bytes, opcode included
		function logic [2:0] length_of(input logic [7:0] b);
			logic [2:0] sizes [EXT_COUNT];
			sizes = '{3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd6, 3'd2, 3'd1, 3'd1,
				3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd2, 3'd6, 3'd2, 3'd1, 3'd2};
			if (b < OCTAVE_BASE) return b[5] ? 3'd1 : 3'd2;
			if (b < OP_EXT_BASE) return 3'd1;
			if (int'(b) < int'(OP_EXT_BASE) + EXT_COUNT) return sizes[b - OP_EXT_BASE];
			return 3'd1;
		endfunction

		// fold one accepted stream byte into the state
		function void take_byte(input logic [7:0] b);
			int idx;
			if (bytes_left == 0) begin
				held_op = b;
				foreach (args[i]) args[i] = '0;
				if (length_of(b) > 1) begin
					bytes_left = length_of(b) - 3'd1;
					return;
				end
			end else begin
				idx = int'(length_of(held_op)) - 1 - int'(bytes_left);
				if (idx >= 0 && idx < NUM_OPERANDS) args[idx] = b;
				bytes_left = bytes_left - 3'd1;
				if (bytes_left > 0) return;
			end
			decode_command();
		endfunction

		// event for the command just completed, with its state update
		function void decode_command();
			event_t ev;
			int     key;
			int     semis;
			ev = '0;
			ev.opcode         = held_op;
			ev.command_length = length_of(held_op);
			for (int i = 0; i < NUM_OPERANDS; i++) ev.operands[i] = args[i];
			ev.pitch      = 12'hFFF;
			ev.event_kind = KIND_CMD;
			ev.flow_kind  = FLOW_NONE;
			if (held_op < OCTAVE_BASE) begin
				key = int'(held_op[3:0]);
				if (!held_op[5]) note_len = args[0];
				ev.event_kind = (key != 0) ? KIND_NOTE : KIND_REST;
				ev.duration   = note_len;
				if (key != 0) begin
					semis    = int'($signed(octave)) * 12 + key - 13 + int'($signed(transpose));
					ev.pitch = semis[11:0];
				end
			end else if (held_op < GATE_BASE) begin
				octave = held_op - OCTAVE_BASE;
			end else if (held_op < PLAIN_BASE) begin
				gate = 3'(held_op - GATE_BASE);
			end else begin
				case (held_op)
					OP_TRANSPOSE: transpose = args[0];
					OP_OCT_UP:    octave = octave + 8'd1;
					OP_OCT_DOWN:  octave = octave - 8'd1;
					OP_REPEAT: begin
						ev.flow_kind    = FLOW_REPEAT;
						ev.repeat_count = (args[0] == COUNT_FOREVER) ? 8'd0 : args[0];
					end
					OP_REPEAT_END: ev.flow_kind = FLOW_REPEAT_END;
					OP_BREAK:      ev.flow_kind = FLOW_BREAK;
					OP_END: begin
						ev.flow_kind  = FLOW_END;
						ev.event_kind = KIND_END;
					end
					default: ;
				endcase
			end
			pending_events = {pending_events, ev};
		endfunction

		function void report(input string what, input logic [15:0] got, input logic [15:0] want);
			if (errors < SHOW_LIMIT)
				$display("[%0t] event error: %s got 0x%0h expected 0x%0h", $time, what, got, want);
			errors++;
		endfunction

		// match one event leaving the block against the oldest expectation
		function void match_event(input logic [79:0] tdata, input logic [4:0] tuser);
			event_t want;
			if (pending_events.size() == 0) begin
				report("unexpected event, opcode", 16'(tdata[7:0]), 16'h0);
				return;
			end
			want = pending_events.pop_front();
			if (tuser[1:0] != want.event_kind) report("event_kind", 16'(tuser[1:0]), 16'(want.event_kind));
			if (tuser[4:2] != want.flow_kind) report("flow_kind", 16'(tuser[4:2]), 16'(want.flow_kind));
			if (tdata[7:0] != want.opcode) report("opcode", 16'(tdata[7:0]), 16'(want.opcode));
			if (tdata[10:8] != want.command_length)
				report("command_length", 16'(tdata[10:8]), 16'(want.command_length));
			for (int i = 0; i < NUM_OPERANDS; i++)
				if (tdata[11 + 8 * i +: 8] != want.operands[i])
					report($sformatf("operand %0d", i + 1), 16'(tdata[11 + 8 * i +: 8]),
						16'(want.operands[i]));
			if (tdata[62:51] != want.pitch) report("pitch", 16'(tdata[62:51]), 16'(want.pitch));
			if (tdata[70:63] != want.duration) report("duration", 16'(tdata[70:63]), 16'(want.duration));
			if (tdata[78:71] != want.repeat_count)
				report("repeat_count", 16'(tdata[78:71]), 16'(want.repeat_count));
			if (tdata[79] != 1'b0) report("pad bit", 16'(tdata[79]), 16'h0);
		endfunction
	endclass

endpackage

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives command bytes into the sequence command decoder: a directed run over
// every opcode class and the track-state corner cases, then random commands
// with random operands mixed with stray bytes. Both stream sides stall at
// random, except over one steady stretch, and every decoded event is checked.
// ----------------------------------------------------------------------------
module testbench;
	import mscd_pkg::*;
	import event_ledger_pkg::*;

	localparam int BYTE_TARGET = 1600;
	localparam int STALL_PCT   = 17;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [4:0]  m_tuser;

	event_ledger board = new();
	bit          steady = 1'b0;
	int          bytes_sent = 0;
	int          quiet_cycles = 0;

	music_sequence_command_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// send one byte, with random idle cycles ahead of it
	task automatic push_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_byte(b);
		bytes_sent++;
	endtask

	// one random command, operands included
	task automatic push_command();
		logic [7:0] op;
		int         pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// stray byte, whatever it starts
			push_byte(8'($urandom_range(0, 255)));
			return;
		end else if (pick < 38) begin
			op = 8'($urandom_range(0, int'(OCTAVE_BASE) - 1));
		end else if (pick < 46) begin
			op = 8'($urandom_range(int'(OCTAVE_BASE), int'(GATE_BASE) - 1));
		end else if (pick < 50) begin
			op = 8'($urandom_range(int'(GATE_BASE), int'(PLAIN_BASE) - 1));
		end else if (pick < 58) begin
			op = 8'($urandom_range(int'(PLAIN_BASE), int'(OP_EXT_BASE) - 1));
		end else if (pick < 78) begin
			op = 8'($urandom_range(int'(OP_EXT_BASE), int'(OP_EXT_BASE) + EXT_COUNT - 1));
		end else if (pick < 95) begin
			case ($urandom_range(0, 6))
				0:       op = OP_TRANSPOSE;
				1:       op = OP_OCT_UP;
				2:       op = OP_OCT_DOWN;
				3:       op = OP_REPEAT;
				4:       op = OP_REPEAT_END;
				5:       op = OP_BREAK;
				default: op = OP_END;
			endcase
		end else begin
			op = 8'($urandom_range(int'(OP_EXT_BASE) + EXT_COUNT, 255));
		end
		push_byte(op);
		for (int i = 1; i < int'(board.length_of(op)); i++) begin
			if (i == 1 && op == OP_REPEAT && $urandom_range(0, 3) == 0)
				push_byte(COUNT_FOREVER);
			else
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// result side: check accepted events, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.match_event(m_tdata, m_tuser);
			m_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("music_sequence_command_decoder_unit: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rest with a length byte, short notes, maximum length
		push_byte(8'h00); push_byte(8'h10);
		push_byte(8'h3F);
		push_byte(8'h2F);
		push_byte(8'h01); push_byte(8'hFF);
		// octave zero, a low note, then octave wrapped below zero
		push_byte(OCTAVE_BASE);
		push_byte(8'h21);
		push_byte(OP_OCT_DOWN);
		push_byte(8'h2C);
		push_byte(8'h47);
		push_byte(OP_OCT_UP);
		push_byte(GATE_BASE); push_byte(8'h4F);
		push_byte(PLAIN_BASE); push_byte(8'hDF);
		// negative transpose
		push_byte(OP_TRANSPOSE); push_byte(8'h80);
		push_byte(8'h20);
		// repeat forever and a repeat count of 0xFE, flow markers
		push_byte(OP_REPEAT); push_byte(COUNT_FOREVER);
		push_byte(OP_REPEAT); push_byte(8'hFE);
		push_byte(OP_REPEAT_END);
		push_byte(OP_BREAK);
		push_byte(OP_END);
		// unused opcodes at the top of the range
		push_byte(8'hF7); push_byte(8'hFF);

		while (bytes_sent < BYTE_TARGET) begin
			steady = (bytes_sent >= 700 && bytes_sent < 1000);
			push_command();
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		while (board.pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (board.errors == 0 && board.pending_events.size() == 0) begin
			$display("music_sequence_command_decoder_unit: match");
		end else begin
			$display("music_sequence_command_decoder_unit: mismatch");
		end
		$finish;
	end

endmodule
